// File: hdl/ofbe_pkg.sv
// ----------------------------------------------------------------------------
// ofbe_pkg
// Types, constants and layout helpers of the optical frame bitmap encoder.
// ----------------------------------------------------------------------------
package ofbe_pkg;

  localparam int unsigned FrameBytes = 1242;
  localparam int unsigned FrameDim   = 108;
  localparam int unsigned HalfCols   = 54;
  localparam int unsigned AddrW      = 11;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW      = 2;
  localparam int unsigned MaxBytes   = 14;
  localparam int unsigned SlotW      = 4;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_START     = 2'd0,
    KIND_END       = 2'd1,
    KIND_START_END = 2'd2,
    KIND_NORMAL    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_BUILD = 2'd2,
    ST_SEND  = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  frame_kind;
    logic [10:0] payload_length;
    logic [15:0] frame_number;
    logic [10:0] byte_index;
    logic [7:0]  data_byte;
    logic [6:0]  row_index;
  } in_item_t;

  typedef struct packed {
    logic [53:0] pixels_left;
    logic [53:0] pixels_right;
    logic [15:0] check_word;
  } out_item_t;

  // classified operation handed from front to back
  typedef struct packed {
    cmd_t        op;
    logic [1:0]  kind;
    logic [10:0] len;
    logic [15:0] number;
    logic [10:0] addr;
    logic [7:0]  data;
    logic [6:0]  row;
  } op_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic take;
  } q_ctl_t;

  // chebyshev ring pattern of an 18x18 finder
  function automatic logic big_finder(input logic [4:0] r, input logic [4:0] c);
    logic [5:0] dr;
    logic [5:0] dc;
    logic [5:0] m;
    logic [4:0] d;
    dr = ({1'b0, r} << 1) >= 6'd17 ? ({1'b0, r} << 1) - 6'd17 : 6'd17 - ({1'b0, r} << 1);
    dc = ({1'b0, c} << 1) >= 6'd17 ? ({1'b0, c} << 1) - 6'd17 : 6'd17 - ({1'b0, c} << 1);
    m  = dr > dc ? dr : dc;
    d  = 5'((m - 6'd1) >> 1);
    return d == 5'd3 || d == 5'd4 || d == 5'd7 || d == 5'd8;
  endfunction

  // payload byte address and bit for a pixel, hit low when not in a region
  function automatic logic [15:0] region_map(input logic [6:0] r, input logic [6:0] c);
    logic       hit;
    logic [10:0] base;
    logic [6:0]  dr;
    logic [6:0]  dc;
    logic [3:0]  bpr;
    logic [10:0] idx;
    hit  = 1'b1;
    base = '0;
    dr   = '0;
    dc   = '0;
    bpr  = '0;
    if (r >= 7'd21 && r < 7'd90 && c >= 7'd2 && c < 7'd18) begin
      base = 11'd0;    dr = r - 7'd21; dc = c - 7'd2;  bpr = 4'd2;
    end else if (r >= 7'd2 && r < 7'd18 && c >= 7'd18 && c < 7'd90) begin
      base = 11'd138;  dr = r - 7'd2;  dc = c - 7'd18; bpr = 4'd9;
    end else if (r >= 7'd18 && r < 7'd90 && c >= 7'd18 && c < 7'd90) begin
      base = 11'd282;  dr = r - 7'd18; dc = c - 7'd18; bpr = 4'd9;
    end else if (r >= 7'd18 && r < 7'd90 && c >= 7'd90 && c < 7'd106) begin
      base = 11'd930;  dr = r - 7'd18; dc = c - 7'd90; bpr = 4'd2;
    end else if (r >= 7'd90 && r < 7'd106 && c >= 7'd18 && c < 7'd90) begin
      base = 11'd1074; dr = r - 7'd90; dc = c - 7'd18; bpr = 4'd9;
    end else if (r >= 7'd90 && r < 7'd98 && c >= 7'd90 && c < 7'd106) begin
      base = 11'd1218; dr = r - 7'd90; dc = c - 7'd90; bpr = 4'd2;
    end else if (r >= 7'd98 && r < 7'd106 && c >= 7'd90 && c < 7'd98) begin
      base = 11'd1234; dr = r - 7'd98; dc = c - 7'd90; bpr = 4'd1;
    end else begin
      hit = 1'b0;
    end
    idx = 11'(base + 11'(dr) * 11'(bpr) + 11'(dc >> 3));
    return {hit, 1'b0, dc[2:0], idx};
  endfunction

endpackage

// File: hdl/ofbe_front.sv
// ----------------------------------------------------------------------------
// ofbe_front
// Accepts items, drops the ones that cause nothing, and queues the rest.
// ----------------------------------------------------------------------------
module ofbe_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ofbe_pkg::in_item_t  item,
  output ofbe_pkg::op_t       q_op,
  input  ofbe_pkg::q_ctl_t    q_ctl_in,
  output ofbe_pkg::q_ctl_t    q_ctl_out
);

  ofbe_pkg::op_t               mem_r [ofbe_pkg::QueueDepth];
  logic [ofbe_pkg::QPtrW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [ofbe_pkg::QPtrW:0]    cnt_r, cnt_nxt;
  logic                        acc, keep, take;
  ofbe_pkg::op_t               op;

  assign full = cnt_r == (ofbe_pkg::QPtrW+1)'(ofbe_pkg::QueueDepth);
  assign acc  = push && !full;
  assign take = q_ctl_in.take && cnt_r != '0;

  always_comb begin
    op.op     = ofbe_pkg::cmd_t'(item.cmd);
    op.kind   = item.frame_kind;
    op.len    = item.payload_length > 11'(ofbe_pkg::FrameBytes) ?
                11'(ofbe_pkg::FrameBytes) : item.payload_length;
    op.number = item.frame_number;
    op.addr   = item.byte_index;
    op.data   = item.data_byte;
    op.row    = item.row_index;
    unique case (ofbe_pkg::cmd_t'(item.cmd))
      ofbe_pkg::CMD_HEADER: keep = 1'b1;
      ofbe_pkg::CMD_WRITE:  keep = item.byte_index < 11'(ofbe_pkg::FrameBytes);
      ofbe_pkg::CMD_READ:   keep = item.row_index < 7'(ofbe_pkg::FrameDim);
      default:              keep = 1'b0;
    endcase
  end

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (acc && keep) begin
      wr_nxt = wr_r + 1'b1;
    end
    if (take) begin
      rd_nxt = rd_r + 1'b1;
    end
    cnt_nxt = cnt_r + (ofbe_pkg::QPtrW+1)'(acc && keep) - (ofbe_pkg::QPtrW+1)'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && keep) begin
      mem_r[wr_r] <= op;
    end
  end

  assign q_op            = mem_r[rd_r];
  assign q_ctl_out.valid = cnt_r != '0;
  assign q_ctl_out.take  = 1'b0;

endmodule

// File: hdl/ofbe_back.sv
// ----------------------------------------------------------------------------
// ofbe_back
// Executes queued operations: frame state, payload buffer and row building.
// ----------------------------------------------------------------------------
module ofbe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ofbe_pkg::op_t       q_op,
  input  ofbe_pkg::q_ctl_t    q_ctl_in,
  output ofbe_pkg::q_ctl_t    q_ctl_out,
  output logic                out_empty,
  input  logic                out_pop,
  output ofbe_pkg::out_item_t out_item
);

  logic [7:0]                 buf_r [ofbe_pkg::FrameBytes];
  logic [7:0]                 rdata_r;
  logic [15:0]                acc_r, acc_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [10:0]                len_r, len_nxt;
  logic [15:0]                num_r, num_nxt;
  ofbe_pkg::state_t           state_r, state_nxt;
  logic [6:0]                 row_r, row_nxt;
  logic [7:0]                 bytes_r [ofbe_pkg::MaxBytes];
  logic [ofbe_pkg::SlotW-1:0] slot_r, slot_nxt;
  logic                       rvalid_r, rvalid_nxt;
  logic [ofbe_pkg::SlotW-1:0] rslot_r;
  logic                       full_r, full_nxt;
  ofbe_pkg::out_item_t        res_r, res_nxt;
  logic                       take, is_start, is_end;
  logic [15:0]                check;
  logic [11:0]                len_ext;
  logic                       wr_en;
  logic [10:0]                rd_addr;
  logic                       rd_en;
  logic [15:0]                slot_map;
  logic [107:0]               row_bits;
  logic [ofbe_pkg::SlotW-1:0] col_slot [ofbe_pkg::FrameDim];
  logic [2:0]                 col_bit [ofbe_pkg::FrameDim];
  logic [ofbe_pkg::FrameDim-1:0] col_hit;

  assign is_start = kind_r == ofbe_pkg::KIND_START || kind_r == ofbe_pkg::KIND_START_END;
  assign is_end   = kind_r == ofbe_pkg::KIND_END || kind_r == ofbe_pkg::KIND_START_END;
  assign check    = acc_r ^ {5'd0, len_r} ^ num_r ^ {14'd0, is_start, is_end};
  assign len_ext  = {1'b0, len_r};

  // every region starts at column 2, 18 or 90, so column c sits in byte slot (c-2)/8
  assign slot_map = ofbe_pkg::region_map(row_r, 7'd2 + {slot_r, 3'b000});

  // per-column byte mapping of the row being built
  always_comb begin
    logic [15:0] m;
    for (int c = 0; c < ofbe_pkg::FrameDim; c++) begin
      m = ofbe_pkg::region_map(row_r, 7'(c));
      col_hit[c]  = m[15];
      col_bit[c]  = m[13:11];
      col_slot[c] = ofbe_pkg::SlotW'(7'(c - 2) >> 3);
    end
  end

  always_comb begin
    logic [6:0] c7;
    logic [3:0] b;
    logic [3:0] dr;
    logic [3:0] dc;
    for (int c = 0; c < ofbe_pkg::FrameDim; c++) begin
      c7 = 7'(c);
      b  = 4'(c7 - 7'd2);
      dr = 4'(row_r >= 7'd102 ? row_r - 7'd102 : 7'd102 - row_r);
      dc = 4'(c7 >= 7'd102 ? c7 - 7'd102 : 7'd102 - c7);
      if (col_hit[c]) begin
        row_bits[c] = bytes_r[col_slot[c]][col_bit[c]];
      end else if (row_r >= 7'd18 && row_r <= 7'd20 && c7 >= 7'd2 && c7 <= 7'd17) begin
        if (row_r == 7'd18) begin
          row_bits[c] = b < 4'd2 ? is_start : b < 4'd4 ? is_end : len_ext[b - 4'd4];
        end else if (row_r == 7'd19) begin
          row_bits[c] = check[b];
        end else begin
          row_bits[c] = num_r[b];
        end
      end else if (row_r >= 7'd98 && row_r <= 7'd106 && c7 >= 7'd98 && c7 <= 7'd106) begin
        row_bits[c] = (dr > dc ? dr : dc) == 4'd2 || (dr > dc ? dr : dc) == 4'd4;
      end else if (row_r < 7'd18 && c7 < 7'd18) begin
        row_bits[c] = ofbe_pkg::big_finder(row_r[4:0], c7[4:0]);
      end else if (row_r < 7'd18 && c7 >= 7'd90) begin
        row_bits[c] = ofbe_pkg::big_finder(row_r[4:0], 5'(c7 - 7'd90));
      end else if (row_r >= 7'd90 && c7 < 7'd18) begin
        row_bits[c] = ofbe_pkg::big_finder(5'(row_r - 7'd90), c7[4:0]);
      end else begin
        row_bits[c] = 1'b1;
      end
    end
  end

  assign take = q_ctl_in.valid && state_r == ofbe_pkg::ST_IDLE;
  assign q_ctl_out.take  = take;
  assign q_ctl_out.valid = 1'b0;
  assign wr_en = take && q_op.op == ofbe_pkg::CMD_WRITE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ofbe_pkg::ST_IDLE: begin
        if (take && q_op.op == ofbe_pkg::CMD_READ) begin
          state_nxt = ofbe_pkg::ST_FETCH;
        end
      end
      ofbe_pkg::ST_FETCH: begin
        if (slot_r == ofbe_pkg::SlotW'(ofbe_pkg::MaxBytes - 1)) begin
          state_nxt = ofbe_pkg::ST_BUILD;
        end
      end
      ofbe_pkg::ST_BUILD: begin
        // wait here while the previous row beat is still held
        if (!full_r || out_pop) begin
          state_nxt = ofbe_pkg::ST_SEND;
        end
      end
      ofbe_pkg::ST_SEND:  state_nxt = ofbe_pkg::ST_IDLE;
      default:            state_nxt = ofbe_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    acc_nxt    = acc_r;
    kind_nxt   = kind_r;
    len_nxt    = len_r;
    num_nxt    = num_r;
    row_nxt    = row_r;
    slot_nxt   = slot_r;
    rvalid_nxt = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = slot_map[10:0];
    full_nxt   = full_r;
    res_nxt    = res_r;
    if (out_pop && full_r) begin
      full_nxt = 1'b0;
    end
    unique case (state_r)
      ofbe_pkg::ST_IDLE: begin
        if (take) begin
          unique case (q_op.op)
            ofbe_pkg::CMD_HEADER: begin
              kind_nxt = q_op.kind;
              num_nxt  = q_op.number;
              acc_nxt  = '0;
              len_nxt  = (q_op.kind == ofbe_pkg::KIND_END ||
                          q_op.kind == ofbe_pkg::KIND_START_END) ?
                         q_op.len : 11'(ofbe_pkg::FrameBytes);
            end
            ofbe_pkg::CMD_WRITE: begin
              if (q_op.addr < len_r) begin
                acc_nxt = acc_r ^ (q_op.addr[0] ? {8'd0, q_op.data} : {q_op.data, 8'd0});
              end
            end
            ofbe_pkg::CMD_READ: begin
              row_nxt  = q_op.row;
              slot_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ofbe_pkg::ST_FETCH: begin
        // one byte slot per cycle; the last slot hits nothing and lets the final read land
        rd_en      = slot_map[15];
        rvalid_nxt = slot_map[15];
        slot_nxt   = slot_r + 1'b1;
      end
      ofbe_pkg::ST_BUILD: begin
        if (!full_r || out_pop) begin
          res_nxt.pixels_left  = row_bits[53:0];
          res_nxt.pixels_right = row_bits[107:54];
          res_nxt.check_word   = check;
        end
      end
      ofbe_pkg::ST_SEND: full_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rvalid_r) begin
      bytes_r[rslot_r] <= rdata_r;
    end
  end

  // single-port payload buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[q_op.addr] <= q_op.data;
    end else if (rd_en) begin
      rdata_r <= buf_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    rslot_r <= slot_r;
    res_r   <= res_nxt;
    row_r   <= row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ofbe_pkg::ST_IDLE;
      acc_r    <= '0;
      kind_r   <= '0;
      len_r    <= 11'(ofbe_pkg::FrameBytes);
      num_r    <= '0;
      slot_r   <= '0;
      rvalid_r <= 1'b0;
      full_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      kind_r   <= kind_nxt;
      len_r    <= len_nxt;
      num_r    <= num_nxt;
      slot_r   <= slot_nxt;
      rvalid_r <= rvalid_nxt && rd_en;
      full_r   <= full_nxt;
    end
  end

  assign out_empty = !full_r;
  assign out_item  = res_r;

endmodule

// File: hdl/optical_frame_bitmap_encoder.sv
// ----------------------------------------------------------------------------
// optical_frame_bitmap_encoder
// Builds one 108x108 frame: header, payload buffer and row readout.
// ----------------------------------------------------------------------------
// order: a header or write takes effect when the back end takes it from the queue;
//   a row read, taken by an idle back end, passes through 14 fetch slots on the
//   single read port of the buffer, build (held while the last beat waits), send
// throughput: one header or write per cycle while the back end is idle
// reset: synchronous, clears queue, frame state and output beat; buffer keeps data
module optical_frame_bitmap_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  ofbe_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output ofbe_pkg::out_item_t out_item
);

  ofbe_pkg::op_t    q_op;
  ofbe_pkg::q_ctl_t f2b, b2f;

  ofbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .item      (in_item),
    .q_op      (q_op),
    .q_ctl_in  (b2f),
    .q_ctl_out (f2b)
  );

  ofbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_op      (q_op),
    .q_ctl_in  (f2b),
    .q_ctl_out (b2f),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    b2f.take |-> f2b.valid) else $error("queue taken while empty");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_item)) else $error("result changed while waiting");

endmodule

// File: tb/sv/optical_frame_bitmap_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// optical_frame_bitmap_encoder_tb
// Drives headers, payload writes and row reads into the frame encoder and
// compares every returned pixel row and check word against a local frame model.
// ----------------------------------------------------------------------------
module optical_frame_bitmap_encoder_tb;

  localparam int StallLimit = 20000;

  // local model of one frame and its expected rows
  class frame_scoreboard;
    logic [7:0]  bytes_q[ofbe_pkg::FrameBytes];
    logic [15:0] chk_acc;
    logic [1:0]  kind;
    logic [10:0] eff_len;
    logic [15:0] number;
    ofbe_pkg::out_item_t rows_due[$];
    int          errors;

    function void clear();
      chk_acc = '0; kind = ofbe_pkg::KIND_START; eff_len = 11'(ofbe_pkg::FrameBytes);
      number = '0;
      rows_due.delete(); errors = 0;
      foreach (bytes_q[i]) bytes_q[i] = '0;
    endfunction

    function bit starts();
      return kind == ofbe_pkg::KIND_START || kind == ofbe_pkg::KIND_START_END;
    endfunction

    function bit ends();
      return kind == ofbe_pkg::KIND_END || kind == ofbe_pkg::KIND_START_END;
    endfunction

    function logic [15:0] check_code();
      return chk_acc ^ 16'(eff_len) ^ number ^ {14'd0, starts(), ends()};
    endfunction

    function bit ring_big(int r, int c);
      int dr, dc, d;
      dr = (2 * r - 17 < 0) ? 17 - 2 * r : 2 * r - 17;
      dc = (2 * c - 17 < 0) ? 17 - 2 * c : 2 * c - 17;
      d = ((dr > dc ? dr : dc) - 1) / 2;
      return d == 3 || d == 4 || d == 7 || d == 8;
    endfunction

    function bit pixel(int r, int c);
      int r0[7], c0[7], nr[7], bpr[7], base[7];
      int dr, dc, b, d;
      logic [15:0] chk;
      r0 = '{21, 2, 18, 18, 90, 90, 98};
      c0 = '{2, 18, 18, 90, 18, 90, 90};
      nr = '{69, 16, 72, 72, 16, 8, 8};
      bpr = '{2, 9, 9, 2, 9, 2, 1};
      base = '{0, 138, 282, 930, 1074, 1218, 1234};
      for (int a = 0; a < 7; a++) begin
        dr = r - r0[a]; dc = c - c0[a];
        if (dr >= 0 && dr < nr[a] && dc >= 0 && dc < bpr[a] * 8)
          return bytes_q[base[a] + dr * bpr[a] + dc / 8][dc % 8];
      end
      if (r >= 18 && r <= 20 && c >= 2 && c <= 17) begin
        b = c - 2;
        if (r == 18) begin
          if (b < 2) return starts();
          if (b < 4) return ends();
          if (b - 4 >= 11) return 1'b0;
          return eff_len[b - 4];
        end
        chk = check_code();
        if (r == 19) return chk[b];
        return number[b];
      end
      if (r >= 98 && r <= 106 && c >= 98 && c <= 106) begin
        dr = (r > 102) ? r - 102 : 102 - r;
        dc = (c > 102) ? c - 102 : 102 - c;
        d = dr > dc ? dr : dc;
        return d == 2 || d == 4;
      end
      if (r < 18 && c < 18) return ring_big(r, c);
      if (r < 18 && c >= 90) return ring_big(r, c - 90);
      if (r >= 90 && c < 18) return ring_big(r - 90, c);
      return 1'b1;
    endfunction

    function void note_item(ofbe_pkg::in_item_t it);
      ofbe_pkg::out_item_t e;
      case (it.cmd)
        ofbe_pkg::CMD_HEADER: begin
          kind = it.frame_kind; number = it.frame_number; chk_acc = '0;
          if (ends())
            eff_len = (it.payload_length > 11'(ofbe_pkg::FrameBytes)) ?
                      11'(ofbe_pkg::FrameBytes) : it.payload_length;
          else eff_len = 11'(ofbe_pkg::FrameBytes);
        end
        ofbe_pkg::CMD_WRITE: if (it.byte_index < ofbe_pkg::FrameBytes) begin
          bytes_q[it.byte_index] = it.data_byte;
          if (it.byte_index < eff_len)
            chk_acc ^= it.byte_index[0] ? {8'd0, it.data_byte} : {it.data_byte, 8'd0};
        end
        ofbe_pkg::CMD_READ: if (it.row_index < ofbe_pkg::FrameDim) begin
          for (int c = 0; c < 54; c++) begin
            e.pixels_left[c] = pixel(it.row_index, c);
            e.pixels_right[c] = pixel(it.row_index, c + 54);
          end
          e.check_word = check_code();
          rows_due.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_row(ofbe_pkg::out_item_t got);
      ofbe_pkg::out_item_t e;
      if (rows_due.size() == 0) begin
        $error("row beat with nothing expected"); errors++; return;
      end
      e = rows_due.pop_front();
      if (got.pixels_left !== e.pixels_left) begin
        $error("pixels_left exp %h got %h", e.pixels_left, got.pixels_left); errors++;
      end
      if (got.pixels_right !== e.pixels_right) begin
        $error("pixels_right exp %h got %h", e.pixels_right, got.pixels_right); errors++;
      end
      if (got.check_word !== e.check_word) begin
        $error("check_word exp %h got %h", e.check_word, got.check_word); errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  ofbe_pkg::in_item_t  in_item = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  ofbe_pkg::out_item_t out_item;

  frame_scoreboard sb;
  int send_idle = 0;
  int recv_idle = 0;
  int stall_cnt = 0;

  optical_frame_bitmap_encoder dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver side and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) sb.check_row(out_item);
      if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cnt <= 0;
      else stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      out_pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // one beat per call, held until accepted
  task automatic push_item(ofbe_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_header(logic [1:0] k, logic [10:0] len, logic [15:0] num);
    ofbe_pkg::in_item_t it;
    it = ofbe_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.cmd = ofbe_pkg::CMD_HEADER; it.frame_kind = k; it.payload_length = len;
    it.frame_number = num;
    push_item(it);
  endtask

  task automatic send_write(logic [10:0] idx, logic [7:0] v);
    ofbe_pkg::in_item_t it;
    it = ofbe_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.cmd = ofbe_pkg::CMD_WRITE; it.byte_index = idx; it.data_byte = v;
    push_item(it);
  endtask

  task automatic send_read(logic [6:0] row);
    ofbe_pkg::in_item_t it;
    it = ofbe_pkg::in_item_t'({$urandom, $urandom, $urandom});
    it.cmd = ofbe_pkg::CMD_READ; it.row_index = row;
    push_item(it);
  endtask

  // every byte gets written once so no read hits an unwritten entry
  task automatic fill_frame();
    for (int i = 0; i < ofbe_pkg::FrameBytes; i++) send_write(11'(i), 8'($urandom));
  endtask

  task automatic random_phase(int n);
    int pick;
    ofbe_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 4)
        send_header(2'($urandom),
                    ($urandom_range(3) == 0) ? 11'($urandom)
                                             : 11'($urandom_range(ofbe_pkg::FrameBytes)),
                    16'($urandom));
      else if (pick < 60)
        send_write(11'($urandom_range(ofbe_pkg::FrameBytes - 1)), 8'($urandom));
      else if (pick < 63)
        send_write(11'($urandom_range(2047, ofbe_pkg::FrameBytes)), 8'($urandom));
      else if (pick < 95) send_read(7'($urandom_range(ofbe_pkg::FrameDim - 1)));
      else begin
        it = ofbe_pkg::in_item_t'({$urandom, $urandom, $urandom});
        if (it.cmd == ofbe_pkg::CMD_READ)
          it.row_index = 7'($urandom_range(127, ofbe_pkg::FrameDim));
        else it.cmd = ofbe_pkg::CMD_NONE;
        push_item(it);
      end
    end
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (sb.rows_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 26; recv_idle = 63;
    fill_frame();
    // directed: all kinds, length extremes, rewrites, bad index, bad rows
    send_header(ofbe_pkg::KIND_END, 11'd2047, 16'hffff);
    send_write(11'd0, 8'hff); send_write(11'd1, 8'h00);
    send_write(11'(ofbe_pkg::FrameBytes - 1), 8'hff);
    send_write(11'd2047, 8'h5a); send_write(11'(ofbe_pkg::FrameBytes), 8'h11);
    send_read(7'd0); send_read(7'd18); send_read(7'd19); send_read(7'd107);
    send_header(ofbe_pkg::KIND_START_END, 11'd0, 16'h0000);
    send_write(11'd0, 8'h80); send_read(7'd19); send_read(7'd20);
    send_header(ofbe_pkg::KIND_START_END, 11'd3, 16'h1234);
    send_write(11'd2, 8'h7e); send_write(11'd2, 8'h7e); send_write(11'd3, 8'h01);
    send_read(7'd19);
    send_header(ofbe_pkg::KIND_NORMAL, 11'd5, 16'h8001);
    send_write(11'd1240, 8'haa); send_read(7'd18); send_read(7'd106);
    send_read(7'd108); send_read(7'd127);
    begin
      ofbe_pkg::in_item_t it;
      it = '1; it.cmd = ofbe_pkg::CMD_NONE; push_item(it);
    end
    send_header(ofbe_pkg::KIND_START, 11'd100, 16'hbeef); send_read(7'd21);
    random_phase(40);
    drain();

    send_idle = 63; recv_idle = 26;
    random_phase(50);
    drain();

    send_idle = 0; recv_idle = 0;
    random_phase(40);
    drain();

    if (sb.errors == 0 && sb.rows_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
hdl/ofbe_pkg.sv
hdl/ofbe_front.sv
hdl/ofbe_back.sv
hdl/optical_frame_bitmap_encoder.sv
tb/sv/optical_frame_bitmap_encoder_tb.sv
